[design/fsss_pkg.sv]
// Shared constants, codes and types of the full-step stepper sequencer.
// No dependencies; fsss_cfg, fsss_ctrl and the top level refer to this package.
`default_nettype none

package fsss_pkg;

  localparam int STEP_COUNT_BITS_DEF = 32;
  localparam int INTERVAL_BITS_DEF   = 24;
  localparam int WAKE_BITS_DEF       = 16;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [31:0] WAKE_TICKS_RESET = 32'd2000;

  // Register index, taken from paddr[2].
  localparam logic REG_WAKE_TICKS = 1'b0;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_MOVE    = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_RELEASE = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_OK        = 3'd1,
    ST_FAIL      = 3'd2,
    ST_BAD_STATE = 3'd3,
    ST_BAD_ARG   = 3'd4,
    ST_BUSY      = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       sleep_n;
    logic       enabled;
    logic       moving;
    logic       fault;
    status_t    status;
  } result_t;

  // Full-step drive pattern: bit0 AIN1, bit1 AIN2, bit2 BIN2, bit3 BIN1.
  function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
    logic [3:0] pat;
    case (phase)
      2'd0: pat = 4'h9;
      2'd1: pat = 4'hA;
      2'd2: pat = 4'h6;
      2'd3: pat = 4'h5;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[design/fsss_in_if.sv]
// Command channel of the stepper sequencer: valid, ready and one command word.
// Depends on nothing but its parameters.
`default_nettype none

interface fsss_in_if #(
  parameter int STEP_COUNT_BITS = 32,
  parameter int INTERVAL_BITS   = 24
);
  logic                       valid;
  logic                       ready;
  logic [2:0]                 cmd;
  logic                       fault_n;
  logic [STEP_COUNT_BITS-1:0] step_count;
  logic                       direction;
  logic [INTERVAL_BITS-1:0]   interval_ticks;

  modport source (
    output valid, cmd, fault_n, step_count, direction, interval_ticks,
    input  ready
  );
  modport sink (
    input  valid, cmd, fault_n, step_count, direction, interval_ticks,
    output ready
  );
endinterface

`default_nettype wire

[design/fsss_out_if.sv]
// Result channel of the stepper sequencer: valid, ready and one result word.
// Fixed widths; no dependencies.
`default_nettype none

interface fsss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic       sleep_n;
  logic       enabled;
  logic       moving;
  logic       fault;
  logic [2:0] status;

  modport source (
    output valid, coils, sleep_n, enabled, moving, fault, status,
    input  ready
  );
  modport sink (
    input  valid, coils, sleep_n, enabled, moving, fault, status,
    output ready
  );
endinterface

`default_nettype wire

[design/fsss_cfg.sv]
// APB-style register file of the stepper sequencer (wake_ticks only).
// Depends on fsss_pkg.
`default_nettype none

module fsss_cfg #(
  parameter int WAKE_BITS = fsss_pkg::WAKE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fsss_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [fsss_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [fsss_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output logic      [WAKE_BITS-1:0]               wake_ticks
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_ticks <= fsss_pkg::WAKE_TICKS_RESET[WAKE_BITS-1:0];
    end else if (wr_en && (paddr[2] == fsss_pkg::REG_WAKE_TICKS)) begin
      wake_ticks <= pwdata[WAKE_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == fsss_pkg::REG_WAKE_TICKS) begin
      prdata = {{(fsss_pkg::APB_DATA_BITS-WAKE_BITS){1'b0}}, wake_ticks};
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

[design/fsss_ctrl.sv]
// Sequencer state and its next-state decision for one command word.
// Depends on fsss_pkg; produces the result word that the top level registers.
`default_nettype none

module fsss_ctrl #(
  parameter int STEP_COUNT_BITS = fsss_pkg::STEP_COUNT_BITS_DEF,
  parameter int INTERVAL_BITS   = fsss_pkg::INTERVAL_BITS_DEF,
  parameter int WAKE_BITS       = fsss_pkg::WAKE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [2:0]                 cmd,
  input  wire logic                       fault_n,
  input  wire logic [STEP_COUNT_BITS-1:0] step_count,
  input  wire logic                       direction,
  input  wire logic [INTERVAL_BITS-1:0]   interval_ticks,
  input  wire logic [WAKE_BITS-1:0]       wake_ticks,
  output fsss_pkg::result_t               res
);

  logic                       enabled_flag, enabled_flag_next;
  logic                       waking_flag, waking_flag_next;
  logic [WAKE_BITS-1:0]       wake_count, wake_count_next;
  logic                       moving_flag, moving_flag_next;
  logic                       move_dir, move_dir_next;
  logic [STEP_COUNT_BITS-1:0] steps_left, steps_left_next;
  logic [INTERVAL_BITS-1:0]   interval_reload, interval_reload_next;
  logic [INTERVAL_BITS-1:0]   interval_count, interval_count_next;
  logic [1:0]                 phase, phase_next;
  logic                       phase_valid, phase_valid_next;
  logic                       fault_latch, fault_latch_next;
  logic                       prev_fault_n;

  logic                       latch_hit;
  logic                       fault_on;
  logic [WAKE_BITS-1:0]       wake_dec;
  logic [INTERVAL_BITS-1:0]   ivl_dec;
  logic                       step_en;
  logic                       step_dir;
  logic [STEP_COUNT_BITS-1:0] step_src;
  logic [INTERVAL_BITS-1:0]   reload_src;
  fsss_pkg::status_t          res_status;

  // The falling edge of the fault pin is latched before anything else.
  assign latch_hit = fault_latch || (prev_fault_n && !fault_n);
  assign fault_on  = !fault_n || latch_hit;
  assign wake_dec  = (wake_count != '0) ? wake_count - 1'b1 : '0;
  assign ivl_dec   = (interval_count != '0) ? interval_count - 1'b1 : '0;

  always_comb begin
    enabled_flag_next    = enabled_flag;
    waking_flag_next     = waking_flag;
    wake_count_next      = wake_count;
    moving_flag_next     = moving_flag;
    move_dir_next        = move_dir;
    steps_left_next      = steps_left;
    interval_reload_next = interval_reload;
    interval_count_next  = interval_count;
    phase_next           = phase;
    phase_valid_next     = phase_valid;
    fault_latch_next     = latch_hit;
    res_status           = fsss_pkg::ST_NONE;
    step_en              = 1'b0;
    step_dir             = move_dir;
    step_src             = steps_left;
    reload_src           = interval_reload;

    if (moving_flag && fault_on) begin
      // A fault ends the move and shuts the driver; the command is dropped.
      enabled_flag_next = 1'b0;
      waking_flag_next  = 1'b0;
      wake_count_next   = '0;
      moving_flag_next  = 1'b0;
      phase_valid_next  = 1'b0;
      res_status        = fsss_pkg::ST_FAIL;
    end else begin
      case (cmd)
        fsss_pkg::CMD_TICK: begin
          if (waking_flag) begin
            wake_count_next = wake_dec;
            if (wake_dec == '0) begin
              waking_flag_next = 1'b0;
              if (fault_on) begin
                enabled_flag_next = 1'b0;
                moving_flag_next  = 1'b0;
                phase_valid_next  = 1'b0;
                res_status        = fsss_pkg::ST_FAIL;
              end else begin
                enabled_flag_next = 1'b1;
                phase_valid_next  = 1'b0;
                res_status        = fsss_pkg::ST_OK;
              end
            end
          end else if (moving_flag) begin
            interval_count_next = ivl_dec;
            if (ivl_dec == '0) begin
              if (steps_left == '0) begin
                moving_flag_next = 1'b0;
                res_status       = fsss_pkg::ST_OK;
              end else begin
                step_en = 1'b1;
              end
            end
          end
        end
        fsss_pkg::CMD_ENABLE: begin
          if (waking_flag || moving_flag) begin
            res_status = fsss_pkg::ST_BUSY;
          end else if (!fault_n) begin
            enabled_flag_next = 1'b0;
            waking_flag_next  = 1'b0;
            wake_count_next   = '0;
            phase_valid_next  = 1'b0;
            res_status        = fsss_pkg::ST_FAIL;
          end else begin
            fault_latch_next = 1'b0;
            phase_valid_next = 1'b0;
            if (wake_ticks == '0) begin
              // A zero wake delay completes at once, with the latch clear.
              enabled_flag_next = 1'b1;
              wake_count_next   = '0;
              res_status        = fsss_pkg::ST_OK;
            end else begin
              waking_flag_next = 1'b1;
              wake_count_next  = wake_ticks;
            end
          end
        end
        fsss_pkg::CMD_DISABLE: begin
          enabled_flag_next = 1'b0;
          waking_flag_next  = 1'b0;
          wake_count_next   = '0;
          moving_flag_next  = 1'b0;
          phase_valid_next  = 1'b0;
          res_status        = fsss_pkg::ST_OK;
        end
        fsss_pkg::CMD_MOVE: begin
          if (step_count == '0) begin
            res_status = fsss_pkg::ST_OK;
          end else if (interval_ticks == '0) begin
            res_status = fsss_pkg::ST_BAD_ARG;
          end else if (waking_flag || moving_flag) begin
            res_status = fsss_pkg::ST_BUSY;
          end else if (!enabled_flag) begin
            res_status = fsss_pkg::ST_BAD_STATE;
          end else if (!fault_n) begin
            enabled_flag_next = 1'b0;
            wake_count_next   = '0;
            phase_valid_next  = 1'b0;
            res_status        = fsss_pkg::ST_FAIL;
          end else begin
            // Pin high clears the latch, so the move starts.
            fault_latch_next     = 1'b0;
            moving_flag_next     = 1'b1;
            move_dir_next        = direction;
            interval_reload_next = interval_ticks;
            step_en              = 1'b1;
            step_dir             = direction;
            step_src             = step_count;
            reload_src           = interval_ticks;
          end
        end
        fsss_pkg::CMD_STOP, fsss_pkg::CMD_RELEASE: begin
          res_status       = moving_flag ? fsss_pkg::ST_BAD_STATE : fsss_pkg::ST_OK;
          moving_flag_next = 1'b0;
          if (cmd == fsss_pkg::CMD_RELEASE) begin
            phase_valid_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (step_en) begin
      if (!phase_valid) begin
        phase_next = step_dir ? 2'd3 : 2'd0;
      end else begin
        phase_next = phase + (step_dir ? 2'd3 : 2'd1);
      end
      phase_valid_next    = 1'b1;
      steps_left_next     = step_src - 1'b1;
      interval_count_next = reload_src;
    end
  end

  always_comb begin
    res.coils   = phase_valid_next ? fsss_pkg::coil_pattern(phase_next) : 4'h0;
    res.sleep_n = enabled_flag_next || waking_flag_next;
    res.enabled = enabled_flag_next;
    res.moving  = moving_flag_next;
    res.fault   = !fault_n || fault_latch_next;
    res.status  = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_flag    <= 1'b0;
      waking_flag     <= 1'b0;
      wake_count      <= '0;
      moving_flag     <= 1'b0;
      move_dir        <= 1'b0;
      steps_left      <= '0;
      interval_reload <= '0;
      interval_count  <= '0;
      phase           <= 2'd0;
      phase_valid     <= 1'b0;
      fault_latch     <= 1'b0;
      prev_fault_n    <= 1'b1;
    end else if (accept) begin
      enabled_flag    <= enabled_flag_next;
      waking_flag     <= waking_flag_next;
      wake_count      <= wake_count_next;
      moving_flag     <= moving_flag_next;
      move_dir        <= move_dir_next;
      steps_left      <= steps_left_next;
      interval_reload <= interval_reload_next;
      interval_count  <= interval_count_next;
      phase           <= phase_next;
      phase_valid     <= phase_valid_next;
      fault_latch     <= fault_latch_next;
      prev_fault_n    <= fault_n;
    end
  end

  a_move_needs_enable: assert property (@(posedge clk) disable iff (rst)
    moving_flag |-> (enabled_flag && !waking_flag && phase_valid))
    else $error("move in progress without an enabled, energized driver");

  a_fail_disables: assert property (@(posedge clk) disable iff (rst)
    (accept && (res.status == fsss_pkg::ST_FAIL)) |=> (!enabled_flag && !moving_flag))
    else $error("fail status left the driver enabled");

  a_fault_edge_latched: assert property (@(posedge clk) disable iff (rst)
    (accept && prev_fault_n && !fault_n) |=> fault_latch)
    else $error("falling fault edge not latched");

  a_wake_count_idle: assert property (@(posedge clk) disable iff (rst)
    !waking_flag |-> (wake_count == '0))
    else $error("wake counter running outside a wake sequence");

endmodule

`default_nettype wire

[design/full_step_stepper_sequencer_unit.sv]
// Top level of the full-step stepper sequencer: command and result channels,
// APB-style register port. Depends on fsss_pkg, fsss_in_if, fsss_out_if,
// fsss_cfg and fsss_ctrl.
`default_nettype none

// Each command word (a 1 us tick or a command, with the sampled fault pin)
// yields exactly one result word holding the coil drive, sleep_n, enabled,
// moving, fault and a status code. The decision for a word is made
// combinationally from the registered sequencer state, so a word is accepted
// in every cycle and its result appears in the output register in the next
// cycle; the only thing that holds the command channel is a full output
// register whose word is not taken in the same cycle. The wake delay and
// the step interval are counted in tick words, not in clock cycles, so the
// rate of motion is set entirely by the tick stream. The wake_ticks register
// (byte address 0, reset 2000) is written through the APB port; write it
// only while no command is in flight. There is no clearing pass after reset.
module full_step_stepper_sequencer_unit #(
  parameter int STEP_COUNT_BITS = fsss_pkg::STEP_COUNT_BITS_DEF,
  parameter int INTERVAL_BITS   = fsss_pkg::INTERVAL_BITS_DEF,
  parameter int WAKE_BITS       = fsss_pkg::WAKE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  fsss_in_if.sink                                 item,
  fsss_out_if.source                              result,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fsss_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [fsss_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [fsss_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready
);

  logic                 accept;
  logic                 out_valid;
  logic [WAKE_BITS-1:0] wake_ticks;
  fsss_pkg::result_t    res;
  fsss_pkg::result_t    result_q;

  // The output register parts the two sides: a new word enters whenever
  // the held result is gone or is being taken right now.
  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;

  fsss_cfg #(
    .WAKE_BITS (WAKE_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .wake_ticks (wake_ticks)
  );

  fsss_ctrl #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS),
    .INTERVAL_BITS   (INTERVAL_BITS),
    .WAKE_BITS       (WAKE_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (item.cmd),
    .fault_n        (item.fault_n),
    .step_count     (item.step_count),
    .direction      (item.direction),
    .interval_ticks (item.interval_ticks),
    .wake_ticks     (wake_ticks),
    .res            (res)
  );

  // Valid flag is control state; the held word itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= res;
    end
  end

  assign result.valid   = out_valid;
  assign result.coils   = result_q.coils;
  assign result.sleep_n = result_q.sleep_n;
  assign result.enabled = result_q.enabled;
  assign result.moving  = result_q.moving;
  assign result.fault   = result_q.fault;
  assign result.status  = result_q.status;

endmodule

`default_nettype wire
